>>> rtl/core/sprite_quad_batcher_assert.svh
//------------------------------------------------------------------------------
// sprite_quad_batcher_assert
// assertion macros for the sprite quad batcher
//------------------------------------------------------------------------------
`ifndef SPRITE_QUAD_BATCHER_ASSERT_SVH
`define SPRITE_QUAD_BATCHER_ASSERT_SVH

// a property that must hold at every edge out of reset
`define SQB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// an implication checked at every edge out of reset
`define SQB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// an implication whose consequent is checked at the next edge
`define SQB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sqb_pkg.sv
//------------------------------------------------------------------------------
// sqb_pkg
// shared types, constants and the sine table for the sprite quad batcher
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqb_pkg;

   localparam int MaxBatchVertices = 4096;
   localparam int SineTableBits    = 10;
   localparam int BatchCap         = MaxBatchVertices / 4;
   localparam int QuadBits         = $clog2(BatchCap + 1);
   localparam int SineEntries      = 1 << SineTableBits;
   localparam int AngleShift       = 16 - SineTableBits;
   localparam int QuarterEntries   = SineEntries / 4;
   localparam int QuarterBits      = SineTableBits - 2;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_FLUSH  = 2'd1;
   localparam logic [1:0] KIND_TOTALS = 2'd2;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_EOF  = 1'b1;

   localparam int QueueDepth = 2;

   // command from front to back: one accepted item, already classified
   typedef struct packed {
      logic               do_flush;
      logic [15:0]        flush_tex;
      logic [QuadBits-1:0] flush_quads;
      logic               do_totals;
      logic [31:0]        sprites;
      logic [15:0]        draws;
      logic               do_quad;
      logic [15:0]        tex;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [29:0]        hx;
      logic [29:0]        hy;
      logic [15:0]        ul;
      logic [15:0]        vb;
      logic [15:0]        uw;
      logic [15:0]        vh;
      logic               rotate;
      logic [SineTableBits-1:0] angle_idx;
      logic [31:0]        color;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [31:0]        color;
      logic [15:0]        tex;
      logic [10:0]        quads;
      logic [31:0]        sprites;
      logic [15:0]        draws;
      logic               last;
   } rsp_type;

   function automatic logic [16:0] quarter_sine(input logic [14:0] p);
      logic [63:0] z2;
      logic [63:0] t;
      z2 = (64'(p) * 64'(p)) >> 14;
      t  = (64'd2320 * z2) >> 14;
      t  = 64'd21024 - t;
      t  = (t * z2) >> 14;
      t  = 64'd51472 - t;
      return 17'((t * 64'(p)) >> 14);
   endfunction

   // first quarter wave, one 16-bit entry per table step
   function automatic logic [QuarterEntries*16-1:0] build_quarter();
      logic [QuarterEntries*16-1:0] tab;
      tab = '0;
      for (int j = 0; j < QuarterEntries; j++)
         tab[16*j +: 16] = 16'(quarter_sine(15'(j << AngleShift)));
      return tab;
   endfunction

   localparam logic [QuarterEntries*16-1:0] QuarterTable = build_quarter();

   // full turn sine from the quarter table, mirrored and negated by quadrant
   function automatic logic signed [17:0] sine_lookup(input logic [SineTableBits-1:0] i);
      logic [1:0]           quad;
      logic [QuarterBits:0] j;
      logic [16:0]          mag;
      logic signed [17:0]   s;
      quad = i[SineTableBits-1 -: 2];
      j    = {1'b0, i[QuarterBits-1:0]};
      if (quad[0]) j = (QuarterBits+1)'(QuarterEntries) - j;
      if (j[QuarterBits]) mag = 17'd32768;
      else mag = {1'b0, QuarterTable[16*j[QuarterBits-1:0] +: 16]};
      s = $signed({1'b0, mag});
      if (quad[1]) s = -s;
      return s;
   endfunction

endpackage

>>> rtl/core/sqb_front.sv
//------------------------------------------------------------------------------
// sqb_front
// accepts sprites and frame ends, keeps batch and frame state, issues commands
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqb_front import sqb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [15:0]        req_texture_id,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_width,
   input  logic [30:0]        req_height,
   input  logic [15:0]        req_uv_left,
   input  logic [15:0]        req_uv_bottom,
   input  logic [15:0]        req_uv_width,
   input  logic [15:0]        req_uv_height,
   input  logic [15:0]        req_angle,
   input  logic [31:0]        req_rgba,
   output logic               cmd_valid,
   input  logic               cmd_full,
   output cmd_type            cmd
);

   logic [15:0]         open_tex_ff, open_tex_in;
   logic [QuadBits-1:0] quads_ff, quads_in;
   logic [31:0]         sprites_ff, sprites_in;
   logic [15:0]         draws_ff, draws_in;
   logic                accept, flush_ok;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;
   assign flush_ok  = (quads_ff != '0) && (open_tex_ff != 16'd0);

   always_comb begin
      cmd = '0;
      cmd_valid   = 1'b0;
      open_tex_in = open_tex_ff;
      quads_in    = quads_ff;
      sprites_in  = sprites_ff;
      draws_in    = draws_ff;
      cmd.flush_tex   = open_tex_ff;
      cmd.flush_quads = quads_ff;
      cmd.tex       = req_texture_id;
      cmd.cx        = req_center_x;
      cmd.cy        = req_center_y;
      cmd.hx        = req_width[30:1];
      cmd.hy        = req_height[30:1];
      cmd.ul        = req_uv_left;
      cmd.vb        = req_uv_bottom;
      cmd.uw        = req_uv_width;
      cmd.vh        = req_uv_height;
      cmd.rotate    = req_angle != 16'd0;
      cmd.angle_idx = req_angle[15:AngleShift];
      cmd.color     = req_rgba;
      if (accept) begin
         if (req_op == OP_EOF) begin
            cmd_valid     = 1'b1;
            cmd.do_flush  = flush_ok;
            cmd.do_totals = 1'b1;
            cmd.sprites   = sprites_ff;
            cmd.draws     = draws_ff + 16'(flush_ok);
            open_tex_in = '0;
            quads_in    = '0;
            sprites_in  = '0;
            draws_in    = '0;
         end else if (req_texture_id != 16'd0) begin
            cmd_valid   = 1'b1;
            cmd.do_quad = 1'b1;
            if (((open_tex_ff != 16'd0) && (req_texture_id != open_tex_ff)) ||
                (32'(quads_ff) >= 32'(BatchCap))) begin
               cmd.do_flush = flush_ok;
               if (flush_ok) begin
                  draws_in = draws_ff + 16'd1;
                  quads_in = '0;
               end
            end
            quads_in    = quads_in + QuadBits'(1);
            sprites_in  = sprites_ff + 32'd1;
            open_tex_in = req_texture_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_tex_ff <= '0;
         quads_ff    <= '0;
         sprites_ff  <= '0;
         draws_ff    <= '0;
      end else begin
         open_tex_ff <= open_tex_in;
         quads_ff    <= quads_in;
         sprites_ff  <= sprites_in;
         draws_ff    <= draws_in;
      end
   end

endmodule

>>> rtl/core/sqb_queue.sv
//------------------------------------------------------------------------------
// sqb_queue
// short command queue between front and back
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqb_queue import sqb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type slot_ff [QueueDepth];
   logic [$clog2(QueueDepth)-1:0] wr_ff, rd_ff;
   logic [$clog2(QueueDepth):0]   count_ff;

   assign full      = count_ff == ($clog2(QueueDepth)+1)'(QueueDepth);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + ($clog2(QueueDepth)+1)'(push) - ($clog2(QueueDepth)+1)'(pop);
      end
   end

endmodule

>>> rtl/core/sqb_back.sv
//------------------------------------------------------------------------------
// sqb_back
// sequences flush, vertices and totals; rotates corners through a pipeline
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqb_back import sqb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_present,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [31:0]        rsp_vertex_color,
   output logic [15:0]        rsp_batch_texture,
   output logic [10:0]        rsp_quad_count,
   output logic [31:0]        rsp_sprite_total,
   output logic [15:0]        rsp_draw_total,
   output logic               rsp_last
);

   // step: 0 flush, 1..4 corners, 5 totals
   logic [2:0] step_ff, step_in, cur;
   logic       issue, adv, gen_v;
   logic       s1_v_ff, s2_v_ff, out_v_ff;
   rsp_type    s1_ff, s2_ff, out_ff, out_in, gen;
   logic [1:0] corner;
   logic signed [31:0] px, py;
   logic signed [31:0] px1_ff, py1_ff, px2_ff, py2_ff;
   logic signed [17:0] s_ff, c_ff;
   logic signed [31:0] cx1_ff, cy1_ff, cx2_ff, cy2_ff;
   logic rot1_ff, rot2_ff;
   logic signed [49:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [51:0] rx, ry;
   logic signed [36:0] fx, fy, sx_s, sy_s;

   // pipeline moves when output is free
   assign adv   = !out_v_ff || !rsp_stall;
   assign issue = cmd_present && adv;

   // no flush step when the command carries no flush
   always_comb begin
      cur = step_ff;
      if (step_ff == 3'd0 && !cmd.do_flush)
         cur = cmd.do_quad ? 3'd1 : 3'd5;
   end

   always_comb begin
      step_in = step_ff;
      cmd_pop = 1'b0;
      if (issue) begin
         if (cur == 3'd4 || cur == 3'd5) begin
            step_in = 3'd0;
            cmd_pop = 1'b1;
         end else if (cur == 3'd0)
            step_in = cmd.do_quad ? 3'd1 : 3'd5;
         else
            step_in = cur + 3'd1;
      end
   end

   always_comb begin
      gen    = '0;
      gen_v  = 1'b0;
      corner = 2'(cur - 3'd1);
      if (issue) begin
         unique case (cur)
            3'd0: begin
               gen_v = cmd.do_flush;
               gen.kind = KIND_FLUSH;
               gen.tex  = cmd.flush_tex;
               gen.quads = 11'(cmd.flush_quads);
            end
            3'd5: begin
               gen_v = 1'b1;
               gen.kind = KIND_TOTALS;
               gen.sprites = cmd.sprites;
               gen.draws = cmd.draws;
               gen.last = 1'b1;
            end
            default: begin
               gen_v = 1'b1;
               gen.kind  = KIND_VERTEX;
               gen.tex_u = 17'(cmd.ul) + ((corner == 2'd1 || corner == 2'd2) ?
                           17'(cmd.uw) : 17'd0);
               gen.tex_v = 17'(cmd.vb) + (corner[1] ? 17'(cmd.vh) : 17'd0);
               gen.color = cmd.color;
               gen.tex   = cmd.tex;
               gen.last  = cur == 3'd4;
            end
         endcase
      end
      px = (corner == 2'd1 || corner == 2'd2) ? 32'(cmd.hx) : -32'(cmd.hx);
      py = corner[1] ? 32'(cmd.hy) : -32'(cmd.hy);
   end

   function automatic logic signed [31:0] sat(input logic signed [36:0] v);
      if (v > 37'sd2147483647) return 32'sh7fffffff;
      if (v < -37'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

   always_comb begin
      rx = 52'(pcx_ff) - 52'(psy_ff) + 52'sd16384;
      ry = 52'(psx_ff) + 52'(pcy_ff) + 52'sd16384;
      fx = rot2_ff ? 37'(rx >>> 15) : 37'(px2_ff);
      fy = rot2_ff ? 37'(ry >>> 15) : 37'(py2_ff);
      sx_s = fx + 37'(cx2_ff);
      sy_s = fy + 37'(cy2_ff);
      out_in = s2_ff;
      if (s2_ff.kind == KIND_VERTEX) begin
         out_in.pos_x = sat(sx_s);
         out_in.pos_y = sat(sy_s);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= gen;
         px1_ff <= px;
         py1_ff <= py;
         s_ff   <= sine_lookup(cmd.angle_idx);
         c_ff   <= sine_lookup(cmd.angle_idx + SineTableBits'(QuarterEntries));
         cx1_ff <= cmd.cx;
         cy1_ff <= cmd.cy;
         rot1_ff <= cmd.rotate;
         s2_ff  <= s1_ff;
         pcx_ff <= 50'(px1_ff * c_ff);
         psy_ff <= 50'(py1_ff * s_ff);
         psx_ff <= 50'(px1_ff * s_ff);
         pcy_ff <= 50'(py1_ff * c_ff);
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
         rot2_ff <= rot1_ff;
         out_ff <= out_in;
      end
      if (reset) begin
         step_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (adv) begin
            s1_v_ff  <= gen_v;
            s2_v_ff  <= s1_v_ff;
            out_v_ff <= s2_v_ff;
         end
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_pos_x         = out_ff.pos_x;
   assign rsp_pos_y         = out_ff.pos_y;
   assign rsp_tex_u         = out_ff.tex_u;
   assign rsp_tex_v         = out_ff.tex_v;
   assign rsp_vertex_color  = out_ff.color;
   assign rsp_batch_texture = out_ff.tex;
   assign rsp_quad_count    = out_ff.quads;
   assign rsp_sprite_total  = out_ff.sprites;
   assign rsp_draw_total    = out_ff.draws;
   assign rsp_last          = out_ff.last;

endmodule

>>> rtl/core/sprite_quad_batcher.sv
//------------------------------------------------------------------------------
// sprite_quad_batcher
// batches sprites by texture and expands each into four quad vertices
//------------------------------------------------------------------------------
// channel   dir  ports
// req       in   req_valid / req_stall, sprite or frame end per beat
// rsp       out  rsp_valid / rsp_stall, vertex, flush or totals per beat
//
// one result per cycle unless stalled; sprite = optional flush step, corners;
// frame end = optional flush step, totals; rotate multipliers are registered
// synchronous reset clears batch and frame counters and all valid flags
// rsp_stall holds the output pipeline; the queue then fills and raises req_stall
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_quad_batcher import sqb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [15:0]        req_texture_id,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_width,
   input  logic [30:0]        req_height,
   input  logic [15:0]        req_uv_left,
   input  logic [15:0]        req_uv_bottom,
   input  logic [15:0]        req_uv_width,
   input  logic [15:0]        req_uv_height,
   input  logic [15:0]        req_angle,
   input  logic [31:0]        req_rgba,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [31:0]        rsp_vertex_color,
   output logic [15:0]        rsp_batch_texture,
   output logic [10:0]        rsp_quad_count,
   output logic [31:0]        rsp_sprite_total,
   output logic [15:0]        rsp_draw_total,
   output logic               rsp_last
);

   cmd_type front_cmd, head_cmd;
   logic    front_valid, q_full, q_ne, q_pop;

   sqb_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_texture_id,
      .req_center_x, .req_center_y, .req_width, .req_height, .req_uv_left,
      .req_uv_bottom, .req_uv_width, .req_uv_height, .req_angle, .req_rgba,
      .cmd_valid(front_valid), .cmd_full(q_full), .cmd(front_cmd)
   );

   sqb_queue u_queue (
      .clock, .reset, .push(front_valid), .push_cmd(front_cmd), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .head(head_cmd)
   );

   sqb_back u_back (
      .clock, .reset, .cmd_present(q_ne), .cmd(head_cmd), .cmd_pop(q_pop),
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_pos_x, .rsp_pos_y, .rsp_tex_u,
      .rsp_tex_v, .rsp_vertex_color, .rsp_batch_texture, .rsp_quad_count,
      .rsp_sprite_total, .rsp_draw_total, .rsp_last
   );

endmodule

>>> rtl/core/sqb_checker.sv
//------------------------------------------------------------------------------
// sqb_checker
// port-level checks on the sprite quad batcher
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprite_quad_batcher_assert.svh"

module sqb_checker import sqb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_sprite_total,
   input logic        rsp_last
);

   `SQB_ASSERT(a_kind_ok, !rsp_valid || rsp_kind == KIND_VERTEX || rsp_kind == KIND_FLUSH || rsp_kind == KIND_TOTALS, "bad result kind")
   `SQB_ASSERT_IMP(a_totals_last, rsp_valid && rsp_kind == KIND_TOTALS, rsp_last, "totals not last")
   `SQB_ASSERT_IMP(a_flush_not_last, rsp_valid && rsp_kind == KIND_FLUSH, !rsp_last, "flush marked last")
   `SQB_ASSERT_IMP(a_total_zero, rsp_valid && rsp_kind != KIND_TOTALS, rsp_sprite_total == '0, "sprite total off totals beat")
   `SQB_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped under stall")

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_kind, .rsp_sprite_total, .rsp_last
);

>>> verif/tb.sv
//------------------------------------------------------------------------------
// tb
// self-checking bench for the sprite quad batcher: a table of directed sprites
// and frame ends, then random batches, each response beat compared field by
// field with a queue of predicted beats, with random idling on both channels
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import sqb_pkg::*;

   typedef struct {
      logic        op;
      logic [15:0] tex;
      logic [31:0] cx, cy;
      logic [30:0] w, h;
      logic [15:0] ul, vb, uw, vh, ang;
      logic [31:0] rgba;
   } sprite_t;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] px, py;
      logic [16:0] u, v;
      logic [31:0] col;
      logic [15:0] tex;
      logic [10:0] quads;
      logic [31:0] spr;
      logic [15:0] drw;
      logic        last;
   } beat_t;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_op = 0;
   logic req_stall;
   logic [15:0] req_texture_id = 0;
   logic signed [31:0] req_center_x = 0, req_center_y = 0;
   logic [30:0] req_width = 0, req_height = 0;
   logic [15:0] req_uv_left = 0, req_uv_bottom = 0, req_uv_width = 0, req_uv_height = 0;
   logic [15:0] req_angle = 0;
   logic [31:0] req_rgba = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [1:0] rsp_kind;
   logic signed [31:0] rsp_pos_x, rsp_pos_y;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [31:0] rsp_vertex_color, rsp_sprite_total;
   logic [15:0] rsp_batch_texture, rsp_draw_total;
   logic [10:0] rsp_quad_count;
   logic rsp_last;

   sprite_quad_batcher dut (.*);

   initial forever #5 clock = ~clock;

   beat_t expected_beats[$];
   int errors = 0;
   bit stim_done = 0;

   // predictor state
   logic [15:0] open_tex = 0;
   int unsigned open_quads = 0;
   logic [31:0] sprite_count = 0;
   logic [15:0] draw_count = 0;

   function automatic longint unsigned poly_q15(longint unsigned p);
      longint unsigned z2, t;
      z2 = (p * p) >> 14;
      t = (64'd2320 * z2) >> 14;
      t = 64'd21024 - t;
      t = (t * z2) >> 14;
      t = 64'd51472 - t;
      return (t * p) >> 14;
   endfunction

   function automatic longint sin_q15(logic [15:0] q);
      longint unsigned p;
      longint s;
      p = q[13:0];
      if (q[14]) p = 16384 - p;
      s = longint'(poly_q15(p));
      return q[15] ? -s : s;
   endfunction

   function automatic longint floor15(longint v);
      return v >>> 15;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic beat_t blank();
      beat_t b;
      b = '{default: 0};
      return b;
   endfunction

   function automatic void queue_beat(beat_t b);
      expected_beats.insert(expected_beats.size(), b);
   endfunction

   task automatic push_flush();
      beat_t b;
      if (open_quads == 0 || open_tex == 0) return;
      b = blank();
      b.kind = KIND_FLUSH;
      b.tex = open_tex;
      b.quads = open_quads[10:0];
      queue_beat(b);
      draw_count++;
      open_quads = 0;
   endtask

   task automatic predict_batch(sprite_t s);
      beat_t b;
      longint hx, hy, px, py, x, y, sn, cs;
      logic [15:0] q;
      int sgx[4] = '{-1, 1, 1, -1};
      int sgy[4] = '{-1, -1, 1, 1};
      if (s.op == OP_EOF) begin
         push_flush();
         b = blank();
         b.kind = KIND_TOTALS;
         b.spr = sprite_count;
         b.drw = draw_count;
         b.last = 1;
         queue_beat(b);
         open_tex = 0; open_quads = 0; sprite_count = 0; draw_count = 0;
         return;
      end
      if (s.tex == 0) return;
      if ((open_tex != 0 && s.tex != open_tex) || open_quads >= BatchCap) push_flush();
      open_tex = s.tex;
      hx = s.w >> 1;
      hy = s.h >> 1;
      q = (s.ang >> AngleShift) << AngleShift;
      sn = sin_q15(q);
      cs = sin_q15(q + 16'd16384);
      for (int i = 0; i < 4; i++) begin
         px = sgx[i] * hx;
         py = sgy[i] * hy;
         if (s.ang != 0) begin
            x = floor15(px * cs - py * sn + 16384);
            y = floor15(px * sn + py * cs + 16384);
         end else begin
            x = px;
            y = py;
         end
         b = blank();
         b.kind = KIND_VERTEX;
         b.px = clamp32(x + longint'($signed(s.cx)));
         b.py = clamp32(y + longint'($signed(s.cy)));
         b.u = 17'(s.ul) + (sgx[i] > 0 ? 17'(s.uw) : 17'd0);
         b.v = 17'(s.vb) + (sgy[i] > 0 ? 17'(s.vh) : 17'd0);
         b.col = s.rgba;
         b.tex = s.tex;
         b.last = (i == 3);
         queue_beat(b);
      end
      open_quads++;
      sprite_count++;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(sprite_t s, bit gaps);
      predict_batch(s);
      req_valid <= 1;
      req_op <= s.op;
      req_texture_id <= s.tex;
      req_center_x <= s.cx;
      req_center_y <= s.cy;
      req_width <= s.w;
      req_height <= s.h;
      req_uv_left <= s.ul;
      req_uv_bottom <= s.vb;
      req_uv_width <= s.uw;
      req_uv_height <= s.vh;
      req_angle <= s.ang;
      req_rgba <= s.rgba;
      do @(posedge clock); while (req_stall);
      if (gaps && $urandom_range(0, 1)) idle_gap();
   endtask

   function automatic sprite_t rand_sprite(logic [15:0] tex, bit wide);
      sprite_t s;
      s.op = OP_DRAW;
      s.tex = tex;
      s.cx = $urandom;
      s.cy = $urandom;
      if (wide) begin
         s.w = 31'($urandom); s.h = 31'($urandom);
      end else begin
         s.w = 31'($urandom_range(0, 32'h00ffffff));
         s.h = 31'($urandom_range(0, 32'h00ffffff));
         s.cx = $signed(s.cx) >>> $urandom_range(0, 8);
         s.cy = $signed(s.cy) >>> $urandom_range(0, 8);
      end
      s.ul = 16'($urandom); s.vb = 16'($urandom);
      s.uw = 16'($urandom); s.vh = 16'($urandom);
      s.ang = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      s.rgba = $urandom;
      return s;
   endfunction

   // directed table: op, tex, cx, cy, w, h, ul, vb, uw, vh, angle, rgba
   sprite_t directed[] = '{
      '{OP_EOF, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_DRAW, 16'd0, 5, 5, 8, 8, 0, 0, 0, 0, 0, 32'h1},
      '{OP_DRAW, 16'd1, 0, 0, 31'h20000, 31'h40000, 0, 0, 16'h8000, 16'h8000, 0, 32'hff0000ff},
      '{OP_DRAW, 16'd1, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
        16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 32'hffffffff},
      '{OP_DRAW, 16'd1, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
        0, 0, 0, 0, 16'h8000, 32'h0},
      '{OP_DRAW, 16'hffff, 32'h10000, 32'h10000, 31'h10000, 31'h10000, 0, 0, 16'h100,
        16'h100, 16'h4000, 32'h12345678},
      '{OP_DRAW, 16'hffff, 0, 0, 31'h10000, 31'h30000, 1, 2, 3, 4, 16'hc000, 32'h1},
      '{OP_DRAW, 16'hffff, 0, 0, 31'h10000, 31'h30000, 1, 2, 3, 4, 16'h003f, 32'h1},
      '{OP_DRAW, 16'hffff, 0, 0, 31'h10000, 31'h30000, 1, 2, 3, 4, 16'hffff, 32'h1},
      '{OP_DRAW, 16'h2, 32'h7fff0000, 32'h80010000, 31'h7fffffff, 31'h7fffffff,
        0, 0, 0, 0, 16'h2000, 32'h2},
      '{OP_DRAW, 16'h2, 0, 0, 31'h1, 31'h1, 0, 0, 0, 0, 16'h6000, 32'h3},
      '{OP_EOF, 16'h5, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1},
      '{OP_EOF, 16'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   initial begin
      sprite_t s;
      logic [15:0] tex;
      int n;
      bit paused;
      paused = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_item(directed[i], 0);
      for (int k = 0; k < 265; k++) begin
         if ($urandom_range(0, 14) == 0) begin
            s = directed[0];
            s.tex = 16'($urandom);
            send_item(s, 1);
         end else if ($urandom_range(0, 19) == 0) begin
            send_item(rand_sprite(16'd0, 1), 1);
         end else begin
            tex = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
            if (tex == 0) tex = 1;
            n = $urandom_range(1, 6);
            for (int j = 0; j < n; j++) send_item(rand_sprite(tex, $urandom_range(0, 4) == 0), 1);
            k += n - 1;
         end
         if (!paused && k >= 130) begin
            paused = 1;
            req_valid <= 0;
            while (expected_beats.size() != 0) @(posedge clock);
            @(posedge clock);
         end
      end
      send_item(directed[0], 1);
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
            repeat ($urandom_range(0, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      beat_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t unexpected beat kind %0d", $time, rsp_kind);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            if ({rsp_kind, rsp_pos_x, rsp_pos_y, rsp_tex_u, rsp_tex_v, rsp_vertex_color,
                 rsp_batch_texture, rsp_quad_count, rsp_sprite_total, rsp_draw_total,
                 rsp_last} !== {e.kind, e.px, e.py, e.u, e.v, e.col, e.tex, e.quads,
                 e.spr, e.drw, e.last}) begin
               $display("%0t mismatch expected k%0d x%h y%h u%h v%h c%h t%h q%0d s%0d d%0d l%0d",
                        $time, e.kind, e.px, e.py, e.u, e.v, e.col, e.tex, e.quads, e.spr,
                        e.drw, e.last);
               $display("%0t            actual k%0d x%h y%h u%h v%h c%h t%h q%0d s%0d d%0d l%0d",
                        $time, rsp_kind, rsp_pos_x, rsp_pos_y, rsp_tex_u, rsp_tex_v,
                        rsp_vertex_color, rsp_batch_texture, rsp_quad_count,
                        rsp_sprite_total, rsp_draw_total, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_beats.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
